@@ src/twsm_pkg.sv @@
// ----------------------------------------------------------------------------
// twsm_pkg
// Shared types and constants of the trie word set: node pool size, alphabet,
// table geometry, result codes, controller states and the command and status
// words between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package twsm_pkg;

   // Trie geometry
   localparam int NODE_COUNT    = 4096;
   localparam int ALPHABET_SIZE = 26;
   localparam int SLOT_COUNT    = NODE_COUNT * ALPHABET_SIZE;

   // Widths
   localparam int NODE_W   = $clog2(NODE_COUNT);
   localparam int USED_W   = $clog2(NODE_COUNT + 1);
   localparam int SLOT_W   = $clog2(SLOT_COUNT);
   localparam int LETTER_W = 5;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 2;

   // Result codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_MARK
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;   // zero one table entry and advance the sweep
      logic accept;  // take a letter and read its child link
      logic step;    // resolve the child link, finish insert or miss
      logic finish;  // decide a query from the word-end mark
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;  // last table entry is being zeroed
      logic need_mark;   // query word walked fully, mark read issued
   } dp_stat_type;

endpackage

`default_nettype wire

@@ src/twsm_ram.sv @@
// ----------------------------------------------------------------------------
// twsm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module twsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/twsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// twsm_ctrl
// Controller of the trie word set: clearing sweep after reset, then one
// walk step per word and an extra mark lookup for query words that reach a node.
// ----------------------------------------------------------------------------
`default_nettype none

module twsm_ctrl
   import twsm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_WALK;
         end
         ST_WALK: begin
            state_in = stat.need_mark ? ST_MARK : ST_IDLE;
         end
         ST_MARK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         ST_WALK: begin
            cmd.step = 1'b1;
         end
         ST_MARK: begin
            cmd.finish = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/twsm_datapath.sv @@
// ----------------------------------------------------------------------------
// twsm_datapath
// Datapath of the trie word set: child link table and word-end marks in RAM,
// cursor, node pool counter, walk failure flag, found counter and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module twsm_datapath
   import twsm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output dp_stat_type              stat,
   input  wire logic                req_cmd,
   input  wire logic [LETTER_W-1:0] req_letter,
   input  wire logic                req_last,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [COUNT_W-1:0]       rsp_match_total
);

   // Word state
   logic [NODE_W-1:0]  cursor_ff, cursor_in;
   logic [USED_W-1:0]  used_ff, used_in;
   logic               failed_ff, failed_in;
   logic [COUNT_W-1:0] found_ff, found_in;
   logic [SLOT_W-1:0]  clear_ff, clear_in;

   // Letter being worked on
   logic               query_ff;
   logic               last_ff;
   logic               bad_ff;
   logic [SLOT_W-1:0]  slot_ff;

   // Result
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;

   // RAM ports
   logic               link_we;
   logic [SLOT_W-1:0]  link_waddr;
   logic [NODE_W-1:0]  link_wdata;
   logic               link_re;
   logic [SLOT_W-1:0]  link_raddr;
   logic [NODE_W-1:0]  link_rdata;
   logic               mark_we;
   logic [NODE_W-1:0]  mark_waddr;
   logic               mark_wdata;
   logic               mark_re;
   logic [NODE_W-1:0]  mark_raddr;
   logic               mark_rdata;

   // Step decode
   logic               letter_ok;
   logic               hit;
   logic               can_alloc;
   logic               walk_ok;
   logic [NODE_W-1:0]  next_node;

   twsm_ram #(.WIDTH(NODE_W), .DEPTH(SLOT_COUNT)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   twsm_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (mark_wdata),
      .rd_en   (mark_re),
      .rd_addr (mark_raddr),
      .rd_data (mark_rdata)
   );

   // Slot of the incoming letter under the cursor
   assign letter_ok  = req_letter < LETTER_W'(ALPHABET_SIZE);
   assign link_raddr = SLOT_W'(cursor_ff) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(req_letter);
   assign link_re    = cmd.accept && letter_ok;

   // Resolve the child link
   assign hit       = link_rdata != '0;
   assign can_alloc = !query_ff && (used_ff < USED_W'(NODE_COUNT));
   assign walk_ok   = !failed_ff && !bad_ff && (hit || can_alloc);
   assign next_node = hit ? link_rdata : used_ff[NODE_W-1:0];

   // Table writes: clearing sweep, new links and word-end marks
   always_comb begin
      link_we    = 1'b0;
      link_waddr = slot_ff;
      link_wdata = used_ff[NODE_W-1:0];
      mark_we    = 1'b0;
      mark_waddr = next_node;
      mark_wdata = 1'b1;
      if (cmd.clear) begin
         link_we    = 1'b1;
         link_waddr = clear_ff;
         link_wdata = '0;
         mark_we    = clear_ff < SLOT_W'(NODE_COUNT);
         mark_waddr = clear_ff[NODE_W-1:0];
         mark_wdata = 1'b0;
      end else if (cmd.step && walk_ok) begin
         link_we = !hit;
         mark_we = last_ff && !query_ff;
      end
   end

   assign mark_raddr = next_node;
   assign mark_re    = cmd.step && walk_ok && last_ff && query_ff;

   // Word state and result next values
   always_comb begin
      cursor_in    = cursor_ff;
      used_in      = used_ff;
      failed_in    = failed_ff;
      found_in     = found_ff;
      clear_in     = clear_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      if (cmd.clear) begin
         clear_in = clear_ff + SLOT_W'(1);
      end
      if (cmd.step) begin
         if (walk_ok && !hit) begin
            used_in = used_ff + USED_W'(1);
         end
         if (last_ff) begin
            // End of word: rewind the walk
            cursor_in = '0;
            failed_in = 1'b0;
            if (!query_ff) begin
               rsp_valid_in = 1'b1;
               status_in    = walk_ok ? STATUS_INSERTED : STATUS_FULL;
            end else if (!walk_ok) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_NOT_FOUND;
            end
         end else if (walk_ok) begin
            cursor_in = next_node;
         end else begin
            failed_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (mark_rdata) begin
            status_in = STATUS_FOUND;
            if (found_ff != '1) found_in = found_ff + COUNT_W'(1);
         end else begin
            status_in = STATUS_NOT_FOUND;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         used_ff      <= USED_W'(1);
         failed_ff    <= 1'b0;
         found_ff     <= '0;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         used_ff      <= used_in;
         failed_ff    <= failed_in;
         found_ff     <= found_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: latch the letter, hold the status
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (cmd.accept) begin
         query_ff <= req_cmd;
         last_ff  <= req_last;
         bad_ff   <= !letter_ok;
         slot_ff  <= link_raddr;
      end
   end

   assign stat.clear_done = cmd.clear && (clear_ff == SLOT_W'(SLOT_COUNT - 1));
   assign stat.need_mark  = mark_re;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_match_total = found_ff;

endmodule

`default_nettype wire

@@ src/trie_word_set_match.sv @@
// ----------------------------------------------------------------------------
// trie_word_set_match
// Trie of lowercase words: insert words and query words arrive one letter
// per word on the request port; the last letter of each word returns one
// result with its status and the running count of found queries.
//
//   channel  ports                                      handshake
//   request  req_cmd, req_letter, req_last              start high, busy low
//   result   rsp_status, rsp_match_total                rsp_valid, one cycle
//
// A letter is accepted with its child link read; the registered link is then
// resolved and a new link written. A query word's last letter adds a state
// for the word-end mark read when its walk reached a node.
// After reset the 106496 link table entries and the marks are zeroed one entry a
// cycle, with busy high. Results cannot be stalled: rsp_valid is a strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_word_set_match
   import twsm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_cmd,
   input  wire logic [LETTER_W-1:0] req_letter,
   input  wire logic                req_last,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [COUNT_W-1:0]       rsp_match_total
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   twsm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (dp_stat),
      .cmd   (dp_cmd)
   );

   twsm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .req_cmd         (req_cmd),
      .req_letter      (req_letter),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_match_total (rsp_match_total)
   );

endmodule

`default_nettype wire

@@ test/trie_word_set_match_tb.sv @@
// ----------------------------------------------------------------------------
// trie_word_set_match_tb
// Self-checking bench for the trie word set. Letters go in through the
// start/busy port one word per handshake. A behavioural trie inside the
// bench mirrors link table, word-end marks, cursor and hit count, and every
// rsp_valid strobe is checked against the oldest pending result. The run
// has a directed table, three random phases with different sender gaps and
// a short closing mix of keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trie_word_set_match_tb;
   import twsm_pkg::*;

   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_QUERY   = 1'b1;
   localparam int   LETTER_TOP  = (1 << LETTER_W) - 1;
   localparam int   MAX_KEY     = 6;
   localparam int   PHASE_WORDS = 520;
   // the link table sweep after reset alone zeroes SLOT_COUNT entries
   localparam int   IDLE_LIMIT  = 4 * SLOT_COUNT + 10000;
   localparam int   DRAIN_WAIT  = 8;

   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   total;
   } result_type;

   typedef struct packed {
      logic                 cmd;
      logic [LETTER_W-1:0]  letter;
      logic                 last;
      logic                 typed;
      result_type           res;
   } stim_row_type;

   typedef struct packed {
      logic [2:0]                         len;
      logic [MAX_KEY-1:0][LETTER_W-1:0]   ch;
   } key_type;

   localparam result_type NO_CHECK = '{STATUS_INSERTED, 16'd0};

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 start      = 1'b0;
   logic                 req_cmd    = 1'b0;
   logic [LETTER_W-1:0]  req_letter = '0;
   logic                 req_last   = 1'b0;
   logic                 busy;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COUNT_W-1:0]   rsp_match_total;

   // behavioural trie
   bit [NODE_W-1:0]      link_mem [SLOT_COUNT];
   bit                   mark_mem [NODE_COUNT];
   bit [NODE_W-1:0]      cur_node;
   int                   pool_used   = 1;
   bit                   walk_bad;
   bit [COUNT_W-1:0]     found_total;

   result_type           pending_results [$];
   key_type              known_keys [$];
   int                   idle_pct;
   int                   words_sent;
   int                   results_seen;
   int                   error_count;
   int                   idle_cycles;

   // letters: a = 0 ... z = 25; codes above z are out of range
   stim_row_type directed_rows [25] = '{
      '{CMD_QUERY,  5'd0,  1'b1, 1'b1, '{STATUS_NOT_FOUND, 16'd0}}, // empty set
      '{CMD_INSERT, 5'd0,  1'b1, 1'b1, '{STATUS_INSERTED,  16'd0}},
      '{CMD_QUERY,  5'd0,  1'b1, 1'b1, '{STATUS_FOUND,     16'd1}},
      '{CMD_INSERT, 5'd25, 1'b0, 1'b0, NO_CHECK},
      '{CMD_INSERT, 5'd0,  1'b1, 1'b1, '{STATUS_INSERTED,  16'd1}},
      '{CMD_QUERY,  5'd25, 1'b1, 1'b1, '{STATUS_NOT_FOUND, 16'd1}}, // bare prefix
      '{CMD_QUERY,  5'd25, 1'b0, 1'b0, NO_CHECK},
      '{CMD_QUERY,  5'd0,  1'b1, 1'b1, '{STATUS_FOUND,     16'd2}},
      '{CMD_INSERT, 5'd31, 1'b1, 1'b1, '{STATUS_FULL,      16'd2}}, // bad letter
      '{CMD_INSERT, 5'd1,  1'b0, 1'b0, NO_CHECK},
      '{CMD_INSERT, 5'd26, 1'b0, 1'b0, NO_CHECK},
      '{CMD_INSERT, 5'd2,  1'b1, 1'b1, '{STATUS_FULL,      16'd2}}, // after failure
      '{CMD_QUERY,  5'd30, 1'b1, 1'b1, '{STATUS_NOT_FOUND, 16'd2}},
      '{CMD_INSERT, 5'd12, 1'b0, 1'b0, NO_CHECK},                  // mixed commands
      '{CMD_QUERY,  5'd13, 1'b1, 1'b0, NO_CHECK},
      '{CMD_QUERY,  5'd25, 1'b0, 1'b0, NO_CHECK},
      '{CMD_INSERT, 5'd1,  1'b1, 1'b0, NO_CHECK},
      '{CMD_QUERY,  5'd25, 1'b0, 1'b0, NO_CHECK},
      '{CMD_QUERY,  5'd1,  1'b1, 1'b0, NO_CHECK},
      '{CMD_QUERY,  5'd0,  1'b0, 1'b0, NO_CHECK},
      '{CMD_QUERY,  5'd31, 1'b0, 1'b0, NO_CHECK},
      '{CMD_QUERY,  5'd0,  1'b1, 1'b0, NO_CHECK},
      '{CMD_INSERT, 5'd0,  1'b1, 1'b0, NO_CHECK},                  // insert twice
      '{CMD_QUERY,  5'd1,  1'b1, 1'b0, NO_CHECK},
      '{CMD_QUERY,  5'd16, 1'b1, 1'b0, NO_CHECK}
   };

   trie_word_set_match u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_letter      (req_letter),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_match_total (rsp_match_total)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Advance the trie by one letter; return 1 when the letter ends a key
   function automatic logic trie_step(input logic cmd, input logic [LETTER_W-1:0] letter,
                                      input logic last, output result_type res);
      int               slot;
      bit [NODE_W-1:0]  next_node;
      res = NO_CHECK;
      if (!walk_bad) begin
         if (letter >= ALPHABET_SIZE) begin
            walk_bad = 1'b1;
         end else begin
            slot      = int'(cur_node) * ALPHABET_SIZE + int'(letter);
            next_node = link_mem[slot];
            if (next_node == '0) begin
               if (cmd == CMD_QUERY || pool_used >= NODE_COUNT) begin
                  walk_bad = 1'b1;
               end else begin
                  next_node      = NODE_W'(pool_used);
                  pool_used      = pool_used + 1;
                  link_mem[slot] = next_node;
               end
            end
            if (!walk_bad) cur_node = next_node;
         end
      end
      if (!last) return 1'b0;
      // decide the key by the command of its last letter
      if (cmd == CMD_INSERT) begin
         if (walk_bad) begin
            res.status = STATUS_FULL;
         end else begin
            mark_mem[cur_node] = 1'b1;
            res.status = STATUS_INSERTED;
         end
      end else if (!walk_bad && mark_mem[cur_node]) begin
         res.status = STATUS_FOUND;
         if (found_total != '1) found_total = found_total + 1'b1;
      end else begin
         res.status = STATUS_NOT_FOUND;
      end
      res.total = found_total;
      cur_node  = '0;
      walk_bad  = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("tb: mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got,
               want);
      error_count = error_count + 1;
   endtask

   // Drive one word and hold it until busy is low; called at a rising edge
   task automatic send_word(input logic cmd, input logic [LETTER_W-1:0] letter,
                            input logic last, input logic typed = 1'b0,
                            input result_type typed_res = NO_CHECK);
      result_type  res;
      logic        produced;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < idle_pct) @(posedge clock);
      end
      start      <= 1'b1;
      req_cmd    <= cmd;
      req_letter <= letter;
      req_last   <= last;
      @(negedge clock);
      while (busy) begin
         @(posedge clock);
         @(negedge clock);
      end
      // taken at the coming edge
      produced = trie_step(cmd, letter, last, res);
      if (produced) begin
         if (typed) res = typed_res;
         pending_results = {pending_results, res};
      end
      words_sent = words_sent + 1;
      @(posedge clock);
   endtask

   task automatic send_key(input key_type key, input logic cmd);
      for (int i = 0; i < int'(key.len); i++)
         send_word(cmd, key.ch[i], i == int'(key.len) - 1);
   endtask

   // Short keys over a few letters mostly, so that prefixes are shared
   function automatic key_type random_key();
      key_type k;
      k.len = 3'($urandom_range(1, MAX_KEY));
      for (int i = 0; i < MAX_KEY; i++)
         k.ch[i] = ($urandom_range(0, 9) < 7) ? LETTER_W'($urandom_range(0, 3))
                                              : LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1));
      return k;
   endfunction

   task automatic run_random_phase(input int sender_idle);
      int       first;
      int       pick;
      int       bad_pos;
      key_type  k;
      idle_pct = sender_idle;
      first    = words_sent;
      while (words_sent - first < PHASE_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40 || known_keys.size() == 0) begin
            k = random_key();
            send_key(k, CMD_INSERT);
            known_keys = {known_keys, k};
         end else if (pick < 85) begin
            // known key, or a prefix of one
            k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            if (pick >= 70) k.len = 3'($urandom_range(1, int'(k.len)));
            send_key(k, CMD_QUERY);
         end else if (pick < 92) begin
            send_key(random_key(), CMD_QUERY);
         end else begin
            // broken key: mixed commands, maybe one letter out of range
            k       = random_key();
            bad_pos = $urandom_range(0, int'(k.len));
            for (int i = 0; i < int'(k.len); i++)
               send_word(1'($urandom_range(0, 1)),
                         (i == bad_pos) ? LETTER_W'($urandom_range(ALPHABET_SIZE, LETTER_TOP))
                                        : k.ch[i],
                         i == int'(k.len) - 1);
         end
      end
   endtask

   // Check each result strobe against the oldest pending result
   always @(negedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         results_seen = results_seen + 1;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, status", int'(rsp_status), -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", int'(rsp_status), int'(want.status));
            if (rsp_match_total !== want.total)
               report_mismatch("match_total", int'(rsp_match_total), int'(want.total));
         end
      end
   end

   // End the run when nothing moves for too long
   always @(negedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: timeout after %0d quiet cycles", idle_cycles);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      idle_pct = 13;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < 25; i++)
         send_word(directed_rows[i].cmd, directed_rows[i].letter, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].res);

      run_random_phase(13);
      run_random_phase(79);
      run_random_phase(0);

      // closing mix: a known key again, then a few random keys
      idle_pct = 13;
      send_key(known_keys[0], CMD_INSERT);
      send_key(known_keys[0], CMD_QUERY);
      repeat (6) send_key(random_key(), 1'($urandom_range(0, 1)));

      // drain
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("tb: %0d letters driven, %0d results checked, %0d mismatches",
               words_sent, results_seen, error_count);
      $display("tb: hit count ended at %0d, node pool %0d of %0d in use",
               found_total, pool_used, NODE_COUNT);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ trie_word_set_match.f @@
src/twsm_pkg.sv
src/twsm_ram.sv
src/twsm_ctrl.sv
src/twsm_datapath.sv
src/trie_word_set_match.sv
test/trie_word_set_match_tb.sv
